FILE: rtl/lrei_pkg.sv
`default_nettype none
package lrei_pkg;

  // rectangle side codes, also the order in which sides are tested
  typedef logic [1:0] side_t;
  localparam side_t SIDE_BOTTOM = 2'd0;
  localparam side_t SIDE_RIGHT  = 2'd1;
  localparam side_t SIDE_TOP    = 2'd2;
  localparam side_t SIDE_LEFT   = 2'd3;

  // configuration register indexes
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_LEFT   = 2'd0;
  localparam reg_idx_t REG_RIGHT  = 2'd1;
  localparam reg_idx_t REG_BOTTOM = 2'd2;
  localparam reg_idx_t REG_TOP    = 2'd3;

endpackage
`default_nettype wire

FILE: rtl/lrei_in_if.sv
`default_nettype none
interface lrei_in_if #(parameter int COORD_BITS = 12);
  logic                    valid;
  logic                    ready;
  logic [COORD_BITS-1:0]   first_x;
  logic [COORD_BITS-1:0]   first_y;
  logic [COORD_BITS-1:0]   second_x;
  logic [COORD_BITS-1:0]   second_y;
  lrei_pkg::side_t         skip_side;

  modport source (output valid, first_x, first_y, second_x, second_y, skip_side,
                  input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, skip_side,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/lrei_out_if.sv
`default_nettype none
interface lrei_out_if #(parameter int OUT_BITS = 20);
  logic                  valid;
  logic                  ready;
  logic                  found;
  lrei_pkg::side_t       hit_side;
  logic [OUT_BITS-1:0]   hit_x;
  logic [OUT_BITS-1:0]   hit_y;

  modport source (output valid, found, hit_side, hit_x, hit_y, input ready);
  modport sink   (input valid, found, hit_side, hit_x, hit_y, output ready);
endinterface
`default_nettype wire

FILE: rtl/lrei_cfg_if.sv
`default_nettype none
interface lrei_cfg_if #(parameter int COORD_BITS = 12);
  logic                    valid;
  logic                    ready;
  lrei_pkg::reg_idx_t      index;
  logic [COORD_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/lrei_edge.sv
`default_nettype none
module lrei_edge #(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [COORD_BITS-1:0]     rect_left,
  input  logic [COORD_BITS-1:0]     rect_right,
  input  logic [COORD_BITS-1:0]     rect_bottom,
  input  logic [COORD_BITS-1:0]     rect_top,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COORD_BITS-1:0]     first_x,
  input  logic [COORD_BITS-1:0]     first_y,
  input  logic [COORD_BITS-1:0]     second_x,
  input  logic [COORD_BITS-1:0]     second_y,
  input  lrei_pkg::side_t           skip_side,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output lrei_pkg::side_t           out_side,
  output logic [COORD_BITS-1:0]     out_coord,
  output logic [2*COORD_BITS-1:0]   out_num,
  output logic [COORD_BITS-1:0]     out_den
);
  localparam int C  = COORD_BITS;
  localparam int PW = 2 * C + 2;
  localparam int NW = 2 * C + 4;
  localparam int BW = 2 * C;
  localparam int NS = 5;

  // stage valid bits and advance chain
  logic          v_r [NS];
  logic          adv [NS+1];

  always_comb begin
    adv[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 1: line direction terms and their magnitudes
  logic [C-1:0]        ax1_r, ay1_r;
  lrei_pkg::side_t     skip1_r;
  logic signed [C:0]   a1_r, b1_r;
  logic [C-1:0]        a1m_r, b1m_r;
  logic signed [C:0]   a1_nxt, b1_nxt, a1n_nxt, b1n_nxt;

  always_comb begin
    a1_nxt  = $signed({1'b0, second_y}) - $signed({1'b0, first_y});
    b1_nxt  = $signed({1'b0, first_x}) - $signed({1'b0, second_x});
    a1n_nxt = a1_nxt[C] ? -a1_nxt : a1_nxt;
    b1n_nxt = b1_nxt[C] ? -b1_nxt : b1_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ax1_r   <= first_x;
      ay1_r   <= first_y;
      skip1_r <= skip_side;
      a1_r    <= a1_nxt;
      b1_r    <= b1_nxt;
      a1m_r   <= a1n_nxt[C-1:0];
      b1m_r   <= b1n_nxt[C-1:0];
    end
  end

  // stage 2: products for the line constant, edge terms and bounds
  logic signed [PW-1:0] pa2_r, pb2_r;
  logic signed [PW-1:0] pe2_r [4];
  logic [BW-1:0]        lo2_r [4];
  logic [BW-1:0]        hi2_r [4];
  logic                 a1neg2_r, b1neg2_r;
  logic [C-1:0]         a1m2_r, b1m2_r;
  lrei_pkg::side_t      skip2_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pa2_r    <= PW'(a1_r) * PW'($signed({1'b0, ax1_r}));
      pb2_r    <= PW'(b1_r) * PW'($signed({1'b0, ay1_r}));
      pe2_r[0] <= PW'(b1_r) * PW'($signed({1'b0, rect_bottom}));
      pe2_r[1] <= PW'(a1_r) * PW'($signed({1'b0, rect_right}));
      pe2_r[2] <= PW'(b1_r) * PW'($signed({1'b0, rect_top}));
      pe2_r[3] <= PW'(a1_r) * PW'($signed({1'b0, rect_left}));
      lo2_r[0] <= BW'(a1m_r) * BW'(rect_left);
      hi2_r[0] <= BW'(a1m_r) * BW'(rect_right);
      lo2_r[1] <= BW'(b1m_r) * BW'(rect_bottom);
      hi2_r[1] <= BW'(b1m_r) * BW'(rect_top);
      lo2_r[2] <= BW'(a1m_r) * BW'(rect_left);
      hi2_r[2] <= BW'(a1m_r) * BW'(rect_right);
      lo2_r[3] <= BW'(b1m_r) * BW'(rect_bottom);
      hi2_r[3] <= BW'(b1m_r) * BW'(rect_top);
      a1neg2_r <= a1_r[C];
      b1neg2_r <= b1_r[C];
      a1m2_r   <= a1m_r;
      b1m2_r   <= b1m_r;
      skip2_r  <= skip1_r;
    end
  end

  // stage 3: free coordinate numerator per side
  logic signed [NW-1:0] n3_r [4];
  logic [BW-1:0]        lo3_r [4];
  logic [BW-1:0]        hi3_r [4];
  logic                 a1neg3_r, b1neg3_r;
  logic [C-1:0]         a1m3_r, b1m3_r;
  lrei_pkg::side_t      skip3_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int s = 0; s < 4; s++) begin
        n3_r[s]  <= NW'(pa2_r) + NW'(pb2_r) - NW'(pe2_r[s]);
        lo3_r[s] <= lo2_r[s];
        hi3_r[s] <= hi2_r[s];
      end
      a1neg3_r <= a1neg2_r;
      b1neg3_r <= b1neg2_r;
      a1m3_r   <= a1m2_r;
      b1m3_r   <= b1m2_r;
      skip3_r  <= skip2_r;
    end
  end

  // stage 4: sign fix and bounds test per side
  logic                 hit4_nxt [4];
  logic [BW-1:0]        num4_nxt [4];
  logic [C-1:0]         edge_c [4];
  logic                 geom_ok [4];

  always_comb begin
    edge_c[0] = rect_bottom;
    edge_c[1] = rect_right;
    edge_c[2] = rect_top;
    edge_c[3] = rect_left;
    for (int s = 0; s < 4; s++) begin
      if (s == 0 || s == 2) begin
        geom_ok[s] = (rect_left != rect_right) && (rect_bottom <= edge_c[s])
                     && (edge_c[s] <= rect_top);
      end else begin
        geom_ok[s] = (rect_bottom != rect_top) && (rect_left <= edge_c[s])
                     && (edge_c[s] <= rect_right);
      end
    end
  end

  always_comb begin
    logic signed [NW-1:0] nn;
    logic signed [NW-1:0] lo_s;
    logic signed [NW-1:0] hi_s;
    logic                 neg;
    logic                 dz;
    for (int s = 0; s < 4; s++) begin
      neg  = (s == 0 || s == 2) ? a1neg3_r : b1neg3_r;
      dz   = (s == 0 || s == 2) ? (a1m3_r == '0) : (b1m3_r == '0);
      nn   = neg ? -n3_r[s] : n3_r[s];
      lo_s = $signed(NW'(lo3_r[s]));
      hi_s = $signed(NW'(hi3_r[s]));
      hit4_nxt[s] = !dz && geom_ok[s] && (skip3_r != lrei_pkg::side_t'(s))
                    && (nn >= lo_s) && (nn <= hi_s);
      num4_nxt[s] = nn[BW-1:0];
    end
  end

  logic                 hit4_r [4];
  logic [BW-1:0]        num4_r [4];
  logic [C-1:0]         a1m4_r, b1m4_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int s = 0; s < 4; s++) begin
        hit4_r[s] <= hit4_nxt[s];
        num4_r[s] <= num4_nxt[s];
      end
      a1m4_r <= a1m3_r;
      b1m4_r <= b1m3_r;
    end
  end

  // stage 5: first side hit wins
  logic                 found_nxt;
  lrei_pkg::side_t      side_nxt;

  always_comb begin
    found_nxt = 1'b0;
    side_nxt  = lrei_pkg::SIDE_BOTTOM;
    for (int s = 3; s >= 0; s--) begin
      if (hit4_r[s]) begin
        found_nxt = 1'b1;
        side_nxt  = lrei_pkg::side_t'(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      out_found <= found_nxt;
      out_side  <= side_nxt;
      out_coord <= edge_c[side_nxt];
      out_num   <= num4_r[side_nxt];
      out_den   <= side_nxt[0] ? b1m4_r : a1m4_r;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lrei_div.sv
`default_nettype none
module lrei_div #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_found,
  input  lrei_pkg::side_t                     in_side,
  input  logic [COORD_BITS-1:0]               in_coord,
  input  logic [2*COORD_BITS-1:0]             in_num,
  input  logic [COORD_BITS-1:0]               in_den,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output lrei_pkg::side_t                     out_side,
  output logic [COORD_BITS-1:0]               out_coord,
  output logic [COORD_BITS+FRAC_BITS-1:0]     out_quot
);
  localparam int C  = COORD_BITS;
  localparam int QW = COORD_BITS + FRAC_BITS;

  // one quotient bit per stage, msb first
  logic              v_r     [QW];
  logic              adv     [QW+1];
  logic              found_r [QW];
  lrei_pkg::side_t   side_r  [QW];
  logic [C-1:0]      coord_r [QW];
  logic [C-1:0]      den_r   [QW];
  logic [C-1:0]      rem_r   [QW];
  logic [QW-1:0]     quot_r  [QW];
  logic [QW-1:0]     dsh_r   [QW];

  always_comb begin
    adv[QW] = out_ready;
    for (int k = QW - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_step
      logic              v_src;
      logic              found_src;
      lrei_pkg::side_t   side_src;
      logic [C-1:0]      coord_src;
      logic [C-1:0]      den_src;
      logic [C-1:0]      rem_src;
      logic [QW-1:0]     quot_src;
      logic [QW-1:0]     dsh_src;
      logic [C:0]        rs;
      logic [C:0]        rd;
      logic              ge;

      if (k == 0) begin : g_first
        // upper dividend bits seed the remainder, lower bits shift in
        assign v_src     = in_valid;
        assign found_src = in_found;
        assign side_src  = in_side;
        assign coord_src = in_coord;
        assign den_src   = in_den;
        assign rem_src   = in_num[2*C-1:C];
        assign quot_src  = '0;
        assign dsh_src   = QW'(in_num[C-1:0]) << FRAC_BITS;
      end else begin : g_next
        assign v_src     = v_r[k-1];
        assign found_src = found_r[k-1];
        assign side_src  = side_r[k-1];
        assign coord_src = coord_r[k-1];
        assign den_src   = den_r[k-1];
        assign rem_src   = rem_r[k-1];
        assign quot_src  = quot_r[k-1];
        assign dsh_src   = dsh_r[k-1];
      end

      // restoring step
      always_comb begin
        rs = {rem_src, dsh_src[QW-1]};
        ge = (rs >= {1'b0, den_src});
        rd = ge ? (rs - {1'b0, den_src}) : rs;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (adv[k]) begin
          v_r[k] <= v_src;
        end
      end

      always_ff @(posedge clk) begin
        if (adv[k]) begin
          found_r[k] <= found_src;
          side_r[k]  <= side_src;
          coord_r[k] <= coord_src;
          den_r[k]   <= den_src;
          rem_r[k]   <= rd[C-1:0];
          quot_r[k]  <= {quot_src[QW-2:0], ge};
          dsh_r[k]   <= dsh_src << 1;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[QW-1];
  assign out_found = found_r[QW-1];
  assign out_side  = side_r[QW-1];
  assign out_coord = coord_r[QW-1];
  assign out_quot  = quot_r[QW-1];

endmodule
`default_nettype wire

FILE: rtl/line_rect_edge_intersect.sv
// channel   dir   handshake      payload
// in_ch     in    valid/ready    first_x first_y second_x second_y skip_side
// out_ch    out   valid/ready    found hit_side hit_x hit_y
// cfg_ch    in    valid/ready    index data (ready always high)
//
// one beat per cycle sustained while out_ch.ready stays high; five geometry
// stages, one divider stage per quotient bit, one output register. the
// bit-per-stage divider sets the depth.
// synchronous active-low reset clears all valid bits and loads the rectangle
// registers with left 0, right all ones, bottom 0, top all ones.
// every stage holds its beat under stall and empty stages still fill, so input
// is taken while a finished result waits, as long as an empty stage remains.
`default_nettype none
module line_rect_edge_intersect #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  lrei_in_if.sink      in_ch,
  lrei_out_if.source   out_ch,
  lrei_cfg_if.sink     cfg_ch
);
  localparam int C  = COORD_BITS;
  localparam int QW = COORD_BITS + FRAC_BITS;

  // rectangle registers
  logic [C-1:0] rect_left_r, rect_right_r, rect_bottom_r, rect_top_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_left_r   <= '0;
      rect_right_r  <= '1;
      rect_bottom_r <= '0;
      rect_top_r    <= '1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        lrei_pkg::REG_LEFT:   rect_left_r   <= cfg_ch.data;
        lrei_pkg::REG_RIGHT:  rect_right_r  <= cfg_ch.data;
        lrei_pkg::REG_BOTTOM: rect_bottom_r <= cfg_ch.data;
        lrei_pkg::REG_TOP:    rect_top_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // geometry pipeline
  logic               e_valid, e_ready, e_found;
  lrei_pkg::side_t    e_side;
  logic [C-1:0]       e_coord, e_den;
  logic [2*C-1:0]     e_num;

  lrei_edge #(.COORD_BITS(COORD_BITS)) u_edge (
    .clk         (clk),
    .rst_n       (rst_n),
    .rect_left   (rect_left_r),
    .rect_right  (rect_right_r),
    .rect_bottom (rect_bottom_r),
    .rect_top    (rect_top_r),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .first_x     (in_ch.first_x),
    .first_y     (in_ch.first_y),
    .second_x    (in_ch.second_x),
    .second_y    (in_ch.second_y),
    .skip_side   (in_ch.skip_side),
    .out_valid   (e_valid),
    .out_ready   (e_ready),
    .out_found   (e_found),
    .out_side    (e_side),
    .out_coord   (e_coord),
    .out_num     (e_num),
    .out_den     (e_den)
  );

  // divider pipeline
  logic               d_valid, d_ready, d_found;
  lrei_pkg::side_t    d_side;
  logic [C-1:0]       d_coord;
  logic [QW-1:0]      d_quot;

  lrei_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (e_valid),
    .in_ready  (e_ready),
    .in_found  (e_found),
    .in_side   (e_side),
    .in_coord  (e_coord),
    .in_num    (e_num),
    .in_den    (e_den),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_found (d_found),
    .out_side  (d_side),
    .out_coord (d_coord),
    .out_quot  (d_quot)
  );

  // output register: place quotient on the free axis, zero on a miss
  logic               out_valid_r, out_found_r;
  lrei_pkg::side_t    out_side_r;
  logic [QW-1:0]      out_x_r, out_y_r;
  logic [QW-1:0]      fixed_c;
  logic               horiz;

  assign d_ready = !out_valid_r || out_ch.ready;
  assign fixed_c = QW'(d_coord) << FRAC_BITS;
  assign horiz   = (d_side == lrei_pkg::SIDE_BOTTOM) || (d_side == lrei_pkg::SIDE_TOP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (d_ready) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      out_found_r <= d_found;
      out_side_r  <= d_found ? d_side : lrei_pkg::SIDE_BOTTOM;
      out_x_r     <= !d_found ? '0 : (horiz ? d_quot : fixed_c);
      out_y_r     <= !d_found ? '0 : (horiz ? fixed_c : d_quot);
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.hit_side = out_side_r;
  assign out_ch.hit_x    = out_x_r;
  assign out_ch.hit_y    = out_y_r;

`ifndef NO_ASSERTIONS
  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.found |->
      out_ch.hit_x == '0 && out_ch.hit_y == '0 && out_ch.hit_side == lrei_pkg::SIDE_BOTTOM)
    else $error("miss result with nonzero fields");

  // a hit lies inside the rectangle's x span
  a_hit_x_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.found |->
      out_ch.hit_x >= (QW'(rect_left_r) << FRAC_BITS) &&
      out_ch.hit_x <= (QW'(rect_right_r) << FRAC_BITS))
    else $error("hit x outside rectangle");

  // a bottom hit sits exactly on the bottom edge
  a_bottom_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.found && out_ch.hit_side == lrei_pkg::SIDE_BOTTOM |->
      out_ch.hit_y == (QW'(rect_bottom_r) << FRAC_BITS))
    else $error("bottom hit off the bottom edge");
`endif

endmodule
`default_nettype wire

FILE: tb/line_rect_edge_intersect_tb.sv
`default_nettype none
module line_rect_edge_intersect_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 26;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic              found;
    lrei_pkg::side_t   hit_side;
    logic [19:0]       hit_x;
    logic [19:0]       hit_y;
  } hit_t;

  logic clk;
  logic rst_n;

  lrei_in_if  #(.COORD_BITS(12)) in_ch ();
  lrei_out_if #(.OUT_BITS(20))   out_ch ();
  lrei_cfg_if #(.COORD_BITS(12)) cfg_ch ();

  line_rect_edge_intersect #(.COORD_BITS(12), .FRAC_BITS(8)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // rectangle copy and pending results
  longint rect_l, rect_r, rect_b, rect_t;
  hit_t   pending_hits[$];
  int     mismatches;
  int     cycles;
  bit     stall_mode;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // floor(n * 256 / d), n >= 0, d > 0
  function automatic logic [19:0] fix_div(longint n, longint d);
    longint q;
    longint r;
    q = n / d;
    r = n % d;
    return 20'((q << 8) + ((r << 8) / d));
  endfunction

  // intersection of the query line with one rectangle edge
  function automatic bit edge_hit(longint ax, longint ay, longint bx, longint by,
                                  longint qx1, longint qy1, longint qx2,
                                  longint qy2, output logic [19:0] hx,
                                  output logic [19:0] hy);
    longint a1, b1, c1, a2, b2, c2, det, nx, ny;
    a1 = by - ay;
    b1 = ax - bx;
    c1 = a1 * ax + b1 * ay;
    a2 = qy2 - qy1;
    b2 = qx1 - qx2;
    c2 = a2 * qx1 + b2 * qy1;
    det = a1 * b2 - a2 * b1;
    hx = '0;
    hy = '0;
    if (det == 0) return 1'b0;
    nx = b2 * c1 - b1 * c2;
    ny = a1 * c2 - a2 * c1;
    if (det < 0) begin
      det = -det;
      nx = -nx;
      ny = -ny;
    end
    if (nx < 0 || ny < 0) return 1'b0;
    if (nx < rect_l * det || nx > rect_r * det) return 1'b0;
    if (ny < rect_b * det || ny > rect_t * det) return 1'b0;
    hx = fix_div(nx, det);
    hy = fix_div(ny, det);
    return 1'b1;
  endfunction

  // first edge hit, in bottom, right, top, left order
  function automatic hit_t first_edge_hit(logic [11:0] ax, logic [11:0] ay,
                                          logic [11:0] bx, logic [11:0] by,
                                          lrei_pkg::side_t skip);
    hit_t        res;
    logic [19:0] hx, hy;
    longint      e[4][4];
    e[lrei_pkg::SIDE_BOTTOM] = '{rect_l, rect_b, rect_r, rect_b};
    e[lrei_pkg::SIDE_RIGHT]  = '{rect_r, rect_b, rect_r, rect_t};
    e[lrei_pkg::SIDE_TOP]    = '{rect_l, rect_t, rect_r, rect_t};
    e[lrei_pkg::SIDE_LEFT]   = '{rect_l, rect_t, rect_l, rect_b};
    res = '0;
    for (int s = 0; s < 4; s++) begin
      if (lrei_pkg::side_t'(s) != skip &&
          edge_hit(ax, ay, bx, by, e[s][0], e[s][1], e[s][2], e[s][3], hx, hy)) begin
        res.found = 1'b1;
        res.hit_side = lrei_pkg::side_t'(s);
        res.hit_x = hx;
        res.hit_y = hy;
        return res;
      end
    end
    return res;
  endfunction

  // send one query beat, valid stays up for a following beat
  task automatic send_query(logic [11:0] ax, logic [11:0] ay, logic [11:0] bx,
                            logic [11:0] by, lrei_pkg::side_t skip);
    in_ch.valid     <= 1'b1;
    in_ch.first_x   <= ax;
    in_ch.first_y   <= ay;
    in_ch.second_x  <= bx;
    in_ch.second_y  <= by;
    in_ch.skip_side <= skip;
    do @(posedge clk); while (!in_ch.ready);
    pending_hits.push_back(first_edge_hit(ax, ay, bx, by, skip));
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // register write, only with the pipe empty
  task automatic write_reg(lrei_pkg::reg_idx_t idx, logic [11:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      lrei_pkg::REG_LEFT:   rect_l = val;
      lrei_pkg::REG_RIGHT:  rect_r = val;
      lrei_pkg::REG_BOTTOM: rect_b = val;
      default:              rect_t = val;
    endcase
    @(negedge clk);
  endtask

  task automatic set_rect(logic [11:0] l, logic [11:0] r, logic [11:0] b,
                          logic [11:0] t);
    drain();
    write_reg(lrei_pkg::REG_LEFT, l);
    write_reg(lrei_pkg::REG_RIGHT, r);
    write_reg(lrei_pkg::REG_BOTTOM, b);
    write_reg(lrei_pkg::REG_TOP, t);
    cfg_ch.valid <= 1'b0;
  endtask

  // directed corners and special cases
  task automatic test_directed();
    send_query(12'd0, 12'd0, 12'd4095, 12'd4095, lrei_pkg::SIDE_BOTTOM);
    send_query(12'd0, 12'd0, 12'd4095, 12'd4095, lrei_pkg::SIDE_LEFT);
    send_query(12'd4095, 12'd0, 12'd0, 12'd4095, lrei_pkg::SIDE_RIGHT);
    send_query(12'd4095, 12'd0, 12'd0, 12'd4095, lrei_pkg::SIDE_TOP);
    send_query(12'd100, 12'd100, 12'd100, 12'd100, lrei_pkg::SIDE_LEFT); // coincident
    send_query(12'd10, 12'd0, 12'd20, 12'd0, lrei_pkg::SIDE_RIGHT);      // along bottom
    send_query(12'd4095, 12'd5, 12'd4095, 12'd9, lrei_pkg::SIDE_BOTTOM); // along right
    send_query(12'd3, 12'd7, 12'd2000, 12'd3001, lrei_pkg::SIDE_BOTTOM);
    send_query(12'd1, 12'd2, 12'd4, 12'd7, lrei_pkg::SIDE_TOP);
    send_query(12'd4000, 12'd10, 12'd4094, 12'd4093, lrei_pkg::SIDE_LEFT);
    send_query(12'hAAA, 12'h555, 12'h555, 12'hAAA, lrei_pkg::SIDE_RIGHT);
    send_query(12'h555, 12'hAAA, 12'hAAA, 12'h555, lrei_pkg::SIDE_BOTTOM);
    set_rect(12'd100, 12'd100, 12'd200, 12'd300);                // zero width
    send_query(12'd0, 12'd0, 12'd400, 12'd500, lrei_pkg::SIDE_TOP);
    send_query(12'd50, 12'd250, 12'd150, 12'd250, lrei_pkg::SIDE_BOTTOM);
    set_rect(12'd500, 12'd100, 12'd300, 12'd200);                // inverted
    send_query(12'd0, 12'd0, 12'd600, 12'd400, lrei_pkg::SIDE_LEFT);
    send_query(12'd0, 12'd4095, 12'd4095, 12'd0, lrei_pkg::SIDE_TOP);
    set_rect(12'd4095, 12'd4095, 12'd4095, 12'd4095);
    send_query(12'd0, 12'd0, 12'd4095, 12'd4095, lrei_pkg::SIDE_BOTTOM);
  endtask

  // random queries in bursts, mostly through the rectangle
  task automatic test_random(int n);
    logic [11:0] c[4];
    int          burst;
    while (n > 0) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && n > 0; i++, n--) begin
        if ($urandom_range(0, 9) < 7) begin
          c[0] = 12'($urandom_range(32'(rect_l), 32'(rect_r)));
          c[1] = 12'($urandom_range(32'(rect_b), 32'(rect_t)));
          c[2] = 12'($urandom_range(0, 4095));
          c[3] = 12'($urandom_range(0, 4095));
        end else begin
          foreach (c[k]) c[k] = 12'($urandom);
        end
        send_query(c[0], c[1], c[2], c[3], lrei_pkg::side_t'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 2) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  endtask

  // random rectangle, ordered or not
  task automatic test_rect_sweep();
    logic [11:0] a, b;
    for (int p = 0; p < 4; p++) begin
      a = 12'($urandom_range(0, 4095));
      b = 12'($urandom_range(0, 4095));
      if (p == 3) set_rect(b, a, a, b);
      else set_rect(a < b ? a : b, a < b ? b : a, 12'($urandom_range(0, 2000)),
                    12'($urandom_range(2000, 4095)));
      test_random(250);
    end
  endtask

  // receiver stalls: random ready while stall_mode is set
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (stall_mode) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= 1'b1;
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    hit_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.found, out_ch.hit_side, out_ch.hit_x, out_ch.hit_y};
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_hits.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("line_rect_edge_intersect_tb: errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.first_x = '0;
    in_ch.first_y = '0;
    in_ch.second_x = '0;
    in_ch.second_y = '0;
    in_ch.skip_side = lrei_pkg::SIDE_BOTTOM;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = lrei_pkg::REG_LEFT;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    cycles = 0;
    stall_mode = 1'b0;
    rect_l = 0;
    rect_r = 4095;
    rect_b = 0;
    rect_t = 4095;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    set_rect(12'd0, 12'd4095, 12'd0, 12'd4095);
    test_random(200);
    stall_mode = 1'b1;
    test_rect_sweep();
    drain();
    stall_mode = 1'b0;
    set_rect(12'd1000, 12'd3000, 12'd500, 12'd3500);
    test_random(100);
    drain();
    if (mismatches == 0) $display("line_rect_edge_intersect_tb: clean");
    else $display("line_rect_edge_intersect_tb: errors");
    $finish;
  end
endmodule
`default_nettype wire
